>>> hdl/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// Miller-Rabin round checker package
// Shared types and constants for the round checker and its modular multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrrc_pkg;

   // Default operand width; the ports always carry the full field width.
   localparam int NUM_BITS_DEF = 63;
   localparam int FIELD_W      = 63;

   typedef enum logic [1:0] {
      ST_PASS      = 2'd0,
      ST_COMPOSITE = 2'd1,
      ST_INVALID   = 2'd2
   } status_type;

   typedef struct packed {
      logic [FIELD_W-1:0] number;
      logic [FIELD_W-1:0] witness;
      logic               last_witness;
   } req_type;

   typedef struct packed {
      status_type round_status;
      logic       probable_prime;
      logic       set_done;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/mrrc_modmul.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes (x * y) mod n one bit of y per cycle, scanning from the top bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mrrc_modmul #(
   parameter int NUM_BITS = mrrc_pkg::NUM_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] x,
   input  wire logic [NUM_BITS-1:0] y,
   input  wire logic [NUM_BITS-1:0] n,
   output logic                     done,
   output logic [NUM_BITS-1:0]      product
);

   localparam int CW = $clog2(NUM_BITS);
   localparam int SW = NUM_BITS + 2;

   logic                busy_ff;
   logic                done_ff;
   logic [CW-1:0]       cnt_ff;
   logic [NUM_BITS-1:0] x_ff;
   logic [NUM_BITS-1:0] y_ff;
   logic [NUM_BITS-1:0] n_ff;
   logic [NUM_BITS-1:0] acc_ff;

   logic [SW-1:0]       sum_in;
   logic [SW-1:0]       n1_in;
   logic [SW-1:0]       n2_in;
   logic [NUM_BITS-1:0] acc_in;

   // With acc and x both below n, 2*acc + x stays below 3n, so one of two
   // parallel subtractions brings it back into range.
   always_comb begin
      n1_in  = SW'(n_ff);
      n2_in  = {1'b0, n_ff, 1'b0};
      sum_in = {1'b0, acc_ff, 1'b0} + (y_ff[NUM_BITS-1] ? SW'(x_ff) : '0);
      if (sum_in >= n2_in) begin
         acc_in = NUM_BITS'(sum_in - n2_in);
      end else if (sum_in >= n1_in) begin
         acc_in = NUM_BITS'(sum_in - n1_in);
      end else begin
         acc_in = NUM_BITS'(sum_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_BITS - 1);
            x_ff    <= x;
            y_ff    <= y;
            n_ff    <= n;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            acc_ff <= acc_in;
            y_ff   <= {y_ff[NUM_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - CW'(1);
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

>>> hdl/miller_rabin_round_checker.sv
// ----------------------------------------------------------------------------
// Miller-Rabin round checker
// Runs one Miller-Rabin round per transaction and tracks a pass flag per set.
// ----------------------------------------------------------------------------
// Each request transaction carries a candidate n, one witness a and a flag that
// marks the last round of a set; each yields exactly one response with the round
// status (pass, composite, invalid), the running AND of all rounds of the set and
// a copy of the set-closing flag. Only the low NUM_BITS bits of number and witness
// are used. The block handles one request at a time and is not ready while it
// works. Invalid and even candidates are settled in S_CHECK and need no multiply.
// An odd candidate uses one bit-serial modular multiplier for everything; a round
// needs NUM_BITS squarings, one extra multiply per set bit of the odd part d of
// n-1 and up to s-1 final squarings. A finished response waits in an output
// register, so the next request is accepted while it is still pending.
`timescale 1ns / 1ps
`default_nettype none

module miller_rabin_round_checker #(
   parameter int NUM_BITS = mrrc_pkg::NUM_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mrrc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mrrc_pkg::rsp_type     rsp_data
);

   localparam int CW = $clog2(NUM_BITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SPLIT,
      S_POW_SQ,
      S_POW_MUL,
      S_POW_NEXT,
      S_TEST,
      S_SQUARE
   } state_type;

   state_type            state_ff;
   logic                 finish_ff;
   logic [NUM_BITS-1:0]  n_ff;
   logic [NUM_BITS-1:0]  a_ff;
   logic                 last_ff;
   logic [NUM_BITS-1:0]  nm1_ff;
   logic [NUM_BITS-1:0]  d_ff;
   logic [CW-1:0]        s_ff;
   logic [CW-1:0]        bit_cnt_ff;
   logic [NUM_BITS-1:0]  x_ff;
   mrrc_pkg::status_type status_ff;
   logic                 all_passed_ff;
   logic                 rsp_valid_ff;
   mrrc_pkg::rsp_type    rsp_data_ff;

   logic                 mm_start_ff;
   logic [NUM_BITS-1:0]  op_x_ff;
   logic [NUM_BITS-1:0]  op_y_ff;
   logic                 mm_done;
   logic [NUM_BITS-1:0]  mm_product;
   logic                 pass_in;

   mrrc_modmul #(
      .NUM_BITS (NUM_BITS)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start_ff),
      .x       (op_x_ff),
      .y       (op_y_ff),
      .n       (n_ff),
      .done    (mm_done),
      .product (mm_product)
   );

   assign req_ready = (state_ff == S_IDLE) && !finish_ff;
   assign pass_in   = all_passed_ff && (status_ff == mrrc_pkg::ST_PASS);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         finish_ff     <= 1'b0;
         all_passed_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         mm_start_ff   <= 1'b0;
      end else begin
         mm_start_ff <= 1'b0;

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         // A finished round moves into the output register once it is free.
         if (finish_ff && (!rsp_valid_ff || rsp_ready)) begin
            finish_ff                  <= 1'b0;
            rsp_valid_ff               <= 1'b1;
            rsp_data_ff.round_status   <= status_ff;
            rsp_data_ff.probable_prime <= pass_in;
            rsp_data_ff.set_done       <= last_ff;
            all_passed_ff              <= last_ff ? 1'b1 : pass_in;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  n_ff     <= req_data.number[NUM_BITS-1:0];
                  a_ff     <= req_data.witness[NUM_BITS-1:0];
                  last_ff  <= req_data.last_witness;
                  state_ff <= S_CHECK;
               end
            end

            S_CHECK: begin
               nm1_ff <= n_ff - NUM_BITS'(1);
               d_ff   <= n_ff - NUM_BITS'(1);
               s_ff   <= '0;
               if ((n_ff < NUM_BITS'(3)) || (a_ff < NUM_BITS'(2)) || (a_ff >= n_ff)) begin
                  status_ff <= mrrc_pkg::ST_INVALID;
                  finish_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else if (!n_ff[0]) begin
                  status_ff <= mrrc_pkg::ST_COMPOSITE;
                  finish_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  state_ff <= S_SPLIT;
               end
            end

            // Strip the trailing zeros of n-1, one per cycle, then start a^d.
            S_SPLIT: begin
               if (!d_ff[0]) begin
                  d_ff <= {1'b0, d_ff[NUM_BITS-1:1]};
                  s_ff <= s_ff + CW'(1);
               end else begin
                  x_ff        <= NUM_BITS'(1);
                  bit_cnt_ff  <= CW'(NUM_BITS - 1);
                  op_x_ff     <= NUM_BITS'(1);
                  op_y_ff     <= NUM_BITS'(1);
                  mm_start_ff <= 1'b1;
                  state_ff    <= S_POW_SQ;
               end
            end

            S_POW_SQ: begin
               if (mm_done) begin
                  x_ff <= mm_product;
                  if (d_ff[NUM_BITS-1]) begin
                     op_x_ff     <= mm_product;
                     op_y_ff     <= a_ff;
                     mm_start_ff <= 1'b1;
                     state_ff    <= S_POW_MUL;
                  end else begin
                     state_ff <= S_POW_NEXT;
                  end
               end
            end

            S_POW_MUL: begin
               if (mm_done) begin
                  x_ff     <= mm_product;
                  state_ff <= S_POW_NEXT;
               end
            end

            S_POW_NEXT: begin
               d_ff <= {d_ff[NUM_BITS-2:0], 1'b0};
               if (bit_cnt_ff == '0) begin
                  state_ff <= S_TEST;
               end else begin
                  bit_cnt_ff  <= bit_cnt_ff - CW'(1);
                  op_x_ff     <= x_ff;
                  op_y_ff     <= x_ff;
                  mm_start_ff <= 1'b1;
                  state_ff    <= S_POW_SQ;
               end
            end

            // s_ff counts the squarings still allowed, plus one.
            S_TEST: begin
               if ((x_ff == NUM_BITS'(1)) || (x_ff == nm1_ff)) begin
                  status_ff <= mrrc_pkg::ST_PASS;
                  finish_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else if (s_ff == CW'(1)) begin
                  status_ff <= mrrc_pkg::ST_COMPOSITE;
                  finish_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  s_ff        <= s_ff - CW'(1);
                  op_x_ff     <= x_ff;
                  op_y_ff     <= x_ff;
                  mm_start_ff <= 1'b1;
                  state_ff    <= S_SQUARE;
               end
            end

            S_SQUARE: begin
               if (mm_done) begin
                  if (mm_product == NUM_BITS'(1)) begin
                     status_ff <= mrrc_pkg::ST_COMPOSITE;
                     finish_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end else if (mm_product == nm1_ff) begin
                     status_ff <= mrrc_pkg::ST_PASS;
                     finish_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end else if (s_ff == CW'(1)) begin
                     status_ff <= mrrc_pkg::ST_COMPOSITE;
                     finish_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end else begin
                     s_ff        <= s_ff - CW'(1);
                     op_x_ff     <= mm_product;
                     op_y_ff     <= mm_product;
                     mm_start_ff <= 1'b1;
                  end
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> verif/tb_miller_rabin_round_checker.sv
// ----------------------------------------------------------------------------
// Miller-Rabin round checker testbench
// Sends sets of rounds through the valid/ready request channel, predicts each
// round's status and the per-set pass flag with wide modular arithmetic, and
// checks every response transaction in order under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_miller_rabin_round_checker;

   localparam int NUM_BITS = mrrc_pkg::NUM_BITS_DEF;
   localparam logic [63:0] VALUE_MASK = (64'd1 << NUM_BITS) - 64'd1;
   localparam int RANDOM_ROUNDS = 75;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   mrrc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   mrrc_pkg::rsp_type rsp_data;

   mrrc_pkg::req_type round_queue[$];
   mrrc_pkg::rsp_type verdict_queue[$];
   logic    set_still_prime = 1'b1;
   int      mismatch_count = 0;

   int burst_left = 1;
   int gap_left = 0;
   int stall_left = 0;
   int calm_left = 0;

   miller_rabin_round_checker #(
      .NUM_BITS(NUM_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The product of two values below 2^63 fits easily in 128 bits.
   function automatic logic [63:0] mul_mod(input logic [63:0] x, input logic [63:0] y,
                                           input logic [63:0] modulus);
      logic [127:0] wide;
      wide = ({64'd0, x} * {64'd0, y}) % {64'd0, modulus};
      return wide[63:0];
   endfunction

   function automatic logic [63:0] pow_mod(input logic [63:0] base,
                                           input logic [63:0] exponent,
                                           input logic [63:0] modulus);
      logic [63:0] result;
      logic [63:0] square;
      logic [63:0] e;
      result = 64'd1;
      square = base;
      e = exponent;
      while (e != 64'd0) begin
         if (e[0]) result = mul_mod(result, square, modulus);
         square = mul_mod(square, square, modulus);
         e = e >> 1;
      end
      return result;
   endfunction

   function automatic mrrc_pkg::status_type round_outcome(input logic [63:0] n,
                                                          input logic [63:0] a);
      logic [63:0] d;
      logic [63:0] x;
      int s;
      int r;
      if (n < 64'd3 || a < 64'd2 || a > n - 64'd1) return mrrc_pkg::ST_INVALID;
      // The round is only defined for odd candidates; even ones are composite.
      if (!n[0]) return mrrc_pkg::ST_COMPOSITE;
      d = n - 64'd1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      x = pow_mod(a, d, n);
      if (x == 64'd1 || x == n - 64'd1) return mrrc_pkg::ST_PASS;
      for (r = 1; r < s; r++) begin
         x = mul_mod(x, x, n);
         if (x == 64'd1) return mrrc_pkg::ST_COMPOSITE;
         if (x == n - 64'd1) return mrrc_pkg::ST_PASS;
      end
      return mrrc_pkg::ST_COMPOSITE;
   endfunction

   task automatic score_round(input mrrc_pkg::req_type item);
      logic [63:0] n;
      logic [63:0] a;
      mrrc_pkg::rsp_type verdict;
      n = {1'b0, item.number} & VALUE_MASK;
      a = {1'b0, item.witness} & VALUE_MASK;
      verdict.round_status = round_outcome(n, a);
      verdict.probable_prime = set_still_prime && (verdict.round_status == mrrc_pkg::ST_PASS);
      verdict.set_done = item.last_witness;
      verdict_queue.insert(verdict_queue.size(), verdict);
      set_still_prime = item.last_witness ? 1'b1 : verdict.probable_prime;
   endtask

   task automatic report_mismatch(input string what, input int expected, input int actual);
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, what, expected, actual);
      mismatch_count++;
   endtask

   function automatic logic [62:0] random_word();
      logic [63:0] raw;
      raw = {$urandom(), $urandom()};
      return raw[62:0];
   endfunction

   // Known primes, strong pseudoprimes and a Carmichael number.
   function automatic logic [62:0] probe_number(input int pick);
      case (pick)
         0: return 63'd2305843009213693951;
         1: return 63'd9223372036854775783;
         2: return 63'd1000000007;
         3: return 63'd2047;
         4: return 63'd3215031751;
         5: return 63'd561;
         6: return 63'd4294967291;
         7: return 63'd2147483647;
         8: return 63'd998244353;
         default: return 63'd65537;
      endcase
   endfunction

   function automatic logic [62:0] random_odd_number();
      logic [62:0] value;
      int width;
      width = ($urandom_range(0, 1) == 1) ? 63 : $urandom_range(2, 62);
      value = random_word() & ((63'd1 << width) - 63'd1);
      value[0] = 1'b1;
      if (value < 63'd3) value = 63'd3;
      return value;
   endfunction

   // A witness in 2 .. n-1 for a candidate of at least 3.
   function automatic logic [62:0] witness_for(input logic [62:0] n);
      logic [63:0] span;
      logic [63:0] pick;
      span = {1'b0, n} - 64'd2;
      pick = 64'd2 + ({$urandom(), $urandom()} % span);
      case ($urandom_range(0, 9))
         0: return 63'd2;
         1: return n - 63'd1;
         default: return pick[62:0];
      endcase
   endfunction

   task automatic queue_round(input logic [62:0] n, input logic [62:0] a, input logic last);
      mrrc_pkg::req_type item;
      item.number = n;
      item.witness = a;
      item.last_witness = last;
      round_queue.insert(round_queue.size(), item);
   endtask

   task automatic drain_all();
      do @(negedge clock);
      while (round_queue.size() != 0 || req_valid || verdict_queue.size() != 0);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         set_still_prime = 1'b1;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) score_round(req_data);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (round_queue.size() > 0) begin
               req_data <= round_queue.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 8);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response stall pattern: short random stalls, with long stretches of no stalling.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (calm_left > 0) begin
         calm_left--;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         case ($urandom_range(0, 9))
            0: calm_left = $urandom_range(500, 20000);
            1, 2, 3: stall_left = $urandom_range(1, 40);
            default: ;
         endcase
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      mrrc_pkg::rsp_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_queue.size() == 0) begin
            report_mismatch("unexpected response", 0, 1);
         end else begin
            expected = verdict_queue.pop_front();
            if (rsp_data.round_status != expected.round_status)
               report_mismatch("round_status", expected.round_status, rsp_data.round_status);
            if (rsp_data.probable_prime != expected.probable_prime)
               report_mismatch("probable_prime", expected.probable_prime,
                               rsp_data.probable_prime);
            if (rsp_data.set_done != expected.set_done)
               report_mismatch("set_done", expected.set_done, rsp_data.set_done);
         end
      end
   end

   initial begin
      int queued;
      int set_length;
      int kind;
      int k;
      logic paused;
      logic last;
      logic [62:0] n;
      logic [62:0] a;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Out-of-range numbers and witnesses; the invalid rounds also clear the set flag.
      queue_round(63'd0, 63'd0, 1'b0);
      queue_round(63'd1, 63'd2, 1'b0);
      queue_round(63'd2, 63'd2, 1'b0);
      queue_round(63'd3, 63'd1, 1'b0);
      queue_round(63'd3, 63'd3, 1'b0);
      queue_round(63'd3, 63'd2, 1'b1);
      queue_round(63'd3, 63'd2, 1'b1);
      // Even candidates are composite for any valid witness; then the odd all-ones candidate.
      queue_round(63'd4, 63'd2, 1'b1);
      queue_round(63'h4000000000000000, 63'd3, 1'b0);
      queue_round({63{1'b1}}, {63{1'b1}} - 63'd1, 1'b1);
      queue_round({63{1'b1}}, {63{1'b1}}, 1'b1);
      // Largest prime below 2^63, including the witness n-1.
      queue_round(probe_number(1), 63'd2, 1'b0);
      queue_round(probe_number(1), probe_number(1) - 63'd1, 1'b0);
      queue_round(probe_number(1), 63'h5555555555555555, 1'b1);
      // Carmichael number, strong pseudoprimes that pass some bases only, then two primes.
      queue_round(probe_number(5), 63'd2, 1'b1);
      queue_round(probe_number(3), 63'd2, 1'b0);
      queue_round(probe_number(3), 63'd3, 1'b1);
      queue_round(probe_number(4), 63'd2, 1'b0);
      queue_round(probe_number(4), 63'd3, 1'b0);
      queue_round(probe_number(4), 63'd5, 1'b0);
      queue_round(probe_number(4), 63'd7, 1'b1);
      queue_round(probe_number(4), 63'd11, 1'b1);
      queue_round(probe_number(0), 63'd3, 1'b0);
      queue_round(probe_number(0), probe_number(0) - 63'd1, 1'b1);
      queue_round(probe_number(8), 63'd3, 1'b1);

      // Hold the sender until everything so far has come back.
      drain_all();

      queued = 0;
      paused = 1'b0;
      while (queued < RANDOM_ROUNDS) begin
         kind = $urandom_range(0, 9);
         set_length = $urandom_range(1, 4);
         if (kind <= 3) n = probe_number($urandom_range(0, 9));
         else if (kind <= 7) n = random_odd_number();
         else begin
            case ($urandom_range(0, 3))
               0: n = 63'($urandom_range(0, 2));
               1: n = random_word() & ~63'd1;
               default: n = random_word();
            endcase
         end
         for (k = 0; k < set_length; k++) begin
            last = (k == set_length - 1);
            if (kind <= 7) begin
               a = witness_for(n);
            end else begin
               case ($urandom_range(0, 2))
                  0: a = random_word();
                  1: a = 63'($urandom_range(0, 3));
                  default: a = (n >= 63'd3) ? witness_for(n) : random_word();
               endcase
               // Broken sets: the closing flag lands anywhere.
               if (kind == 9) last = 1'($urandom_range(0, 1));
            end
            queue_round(n, a, last);
            queued++;
         end
         if (!paused && queued >= RANDOM_ROUNDS / 2) begin
            drain_all();
            paused = 1'b1;
         end
      end

      drain_all();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #60_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> files.f
hdl/mrrc_pkg.sv
hdl/mrrc_modmul.sv
hdl/miller_rabin_round_checker.sv
verif/tb_miller_rabin_round_checker.sv
